>>> rtl/adc_gain_scale_trimmed_mean_defines.svh
// ----------------------------------------------------------------------------
// adc_gain_scale_trimmed_mean_defines.svh
// Assertion macros shared by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef ADC_GAIN_SCALE_TRIMMED_MEAN_DEFINES_SVH
`define ADC_GAIN_SCALE_TRIMMED_MEAN_DEFINES_SVH

// same-cycle implication
`define AGSTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AGSTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/agstm_pkg.sv
// ----------------------------------------------------------------------------
// agstm_pkg
// Widths, constants, gain table and shared types of the gain-scale averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package agstm_pkg;

  localparam int unsigned ChW    = 5;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned MvW    = 18;
  localparam int unsigned SumW   = 22;
  localparam int unsigned CntW   = 5;
  localparam int unsigned GainKW = 21;
  localparam int unsigned ProdW  = GainKW + CodeW;
  localparam int unsigned DivW   = 4;
  localparam int unsigned Shift  = 13;

  localparam logic [CntW-1:0] CntReset = 5'd5;
  localparam logic [CntW-1:0] CntMin   = 5'd3;
  localparam logic [CntW-1:0] CntMax   = 5'd16;
  localparam logic [MvW-1:0]  MvMax    = 18'd142612;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // gain times 8, times 1000
  function automatic logic [GainKW-1:0] gain_k(input logic [ChW-1:0] ch);
    logic [GainKW-1:0] g;
    unique case (ch)
      5'd0:    g = 21'd1142000;
      5'd2:    g = 21'd15000;
      5'd7:    g = 21'd40000;
      5'd8:    g = 21'd50000;
      5'd9:    g = 21'd90000;
      5'd10:   g = 21'd55000;
      5'd11:   g = 21'd15000;
      5'd14:   g = 21'd55000;
      5'd1, 5'd3, 5'd4, 5'd5, 5'd6, 5'd12, 5'd13, 5'd15, 5'd16:
               g = 21'd8000;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

>>> rtl/agstm_div.sv
// ----------------------------------------------------------------------------
// agstm_div
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module agstm_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [agstm_pkg::SumW-1:0]    dividend_i,
  input  wire logic [agstm_pkg::DivW-1:0]    divisor_i,
  output agstm_pkg::div_stat_t               stat_o,
  output logic      [agstm_pkg::MvW-1:0]     quotient_o
);
  import agstm_pkg::*;

  localparam logic [CntW-1:0] LastBit = CntW'(SumW - 1);

  logic [SumW-1:0] work_q, work_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DivW:0]   trial;
  logic            ge;

  assign trial = {rem_q, work_q[SumW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? DivW'(trial - {1'b0, dvs_q}) : DivW'(trial);
      work_d = {work_q[SumW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LastBit) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = work_q[MvW-1:0];

endmodule
`default_nettype wire

>>> rtl/adc_gain_scale_trimmed_mean.sv
// ----------------------------------------------------------------------------
// adc_gain_scale_trimmed_mean
// ADC code to millivolt scaling with min/max-rejecting batch average.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. After acceptance a sample passes the
// bit-serial multiplier (one code bit a cycle), the batch update and the load
// of the output register, which waits until that register is free, and the
// block then returns to idle to take the next beat. A sample that closes a
// batch also passes the bit-serial divider that forms the trimmed mean: it
// forms the quotient bits and then hands the quotient over. A new sample is
// taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "adc_gain_scale_trimmed_mean_defines.svh"
module adc_gain_scale_trimmed_mean #(
  parameter int unsigned CHANNELS = 17
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [agstm_pkg::ChW-1:0]      channel_index_i,
  input  wire logic [agstm_pkg::CodeW-1:0]    adc_code_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [agstm_pkg::MvW-1:0]      scaled_millivolts_o,
  output logic                                average_valid_o,
  output logic      [agstm_pkg::MvW-1:0]      trimmed_average_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [agstm_pkg::CntW-1:0]     cfg_data_i
);
  import agstm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [3:0] MulLast = 4'(CodeW - 1);

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   scount_q, scount_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [MvW-1:0]    min_q, min_d;
  logic [MvW-1:0]    max_q, max_d;
  logic [CntW-1:0]   seen_q, seen_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic [GainKW-1:0] gk_q, gk_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [3:0]        mcnt_q, mcnt_d;
  logic              comp_q, comp_d;
  logic              ovalid_q, ovalid_d;
  logic [MvW-1:0]    omv_q, omv_d;
  logic              oavv_q, oavv_d;
  logic [MvW-1:0]    oavg_q, oavg_d;

  logic [GainKW:0]   mul_add;
  logic [MvW-1:0]    mv;
  logic [CntW-1:0]   n;
  logic [SumW-1:0]   new_sum;
  logic [MvW-1:0]    new_min;
  logic [MvW-1:0]    new_max;
  logic [CntW-1:0]   new_seen;
  logic [MvW:0]      drop;
  logic [SumW-1:0]   trimmed;
  logic              div_start;
  div_stat_t         div_stat;
  logic [MvW-1:0]    div_q;
  logic              out_free;
  logic              in_acc;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !ovalid_q || out_ready_i;

  assign mul_add = {1'b0, prod_q[ProdW-1:CodeW]} + (code_q[0] ? {1'b0, gk_q} : '0);
  assign mv      = prod_q[ProdW-1:Shift];

  always_comb begin
    priority if (scount_q < CntMin) n = CntMin;
    else if (scount_q > CntMax)     n = CntMax;
    else                            n = scount_q;
  end

  assign new_sum  = sum_q + SumW'(mv);
  assign new_min  = (mv < min_q) ? mv : min_q;
  assign new_max  = (mv > max_q) ? mv : max_q;
  assign new_seen = seen_q + 1'b1;
  assign drop     = {1'b0, new_min} + {1'b0, new_max};
  assign trimmed  = (new_sum >= SumW'(drop)) ? (new_sum - SumW'(drop)) : '0;

  always_comb begin
    state_d   = state_q;
    scount_d  = scount_q;
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    seen_d    = seen_q;
    code_d    = code_q;
    gk_d      = gk_q;
    prod_d    = prod_q;
    mcnt_d    = mcnt_q;
    comp_d    = comp_q;
    ovalid_d  = ovalid_q;
    omv_d     = omv_q;
    oavv_d    = oavv_q;
    oavg_d    = oavg_q;
    div_start = 1'b0;

    if (cfg_valid_i) begin
      scount_d = cfg_data_i;
    end
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          code_d  = adc_code_i;
          gk_d    = (32'(channel_index_i) < CHANNELS) ? gain_k(channel_index_i) : '0;
          prod_d  = '0;
          mcnt_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = {mul_add, prod_q[CodeW-1:1]};
        code_d = {1'b0, code_q[CodeW-1:1]};
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == MulLast) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (new_seen >= n) begin
          div_start = 1'b1;
          comp_d    = 1'b1;
          sum_d     = '0;
          min_d     = '1;
          max_d     = '0;
          seen_d    = '0;
          state_d   = S_DIV;
        end else begin
          comp_d  = 1'b0;
          sum_d   = new_sum;
          min_d   = new_min;
          max_d   = new_max;
          seen_d  = new_seen;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          omv_d    = mv;
          oavv_d   = comp_q;
          oavg_d   = comp_q ? div_q : '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scount_q <= CntReset;
      sum_q    <= '0;
      min_q    <= '1;
      max_q    <= '0;
      seen_q   <= '0;
      mcnt_q   <= '0;
      comp_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      scount_q <= scount_d;
      sum_q    <= sum_d;
      min_q    <= min_d;
      max_q    <= max_d;
      seen_q   <= seen_d;
      mcnt_q   <= mcnt_d;
      comp_q   <= comp_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    gk_q   <= gk_d;
    prod_q <= prod_d;
    omv_q  <= omv_d;
    oavv_q <= oavv_d;
    oavg_q <= oavg_d;
  end

  agstm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (trimmed),
    .divisor_i  (DivW'(n - 5'd2)),
    .stat_o     (div_stat),
    .quotient_o (div_q)
  );

  assign in_ready_o          = (state_q == S_IDLE);
  assign cfg_ready_o         = 1'b1;
  assign out_valid_o         = ovalid_q;
  assign scaled_millivolts_o = omv_q;
  assign average_valid_o     = oavv_q;
  assign trimmed_average_o   = oavg_q;

  `AGSTM_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_o)
  `AGSTM_ASSERT_NOW(a_avg_zero_off_batch, out_valid_o && !average_valid_o,
                    trimmed_average_o == '0)
  `AGSTM_ASSERT_NOW(a_mv_in_range, out_valid_o, scaled_millivolts_o <= MvMax)
  `AGSTM_ASSERT_NOW(a_div_only_in_div, div_stat.busy || div_stat.done, state_q == S_DIV)

endmodule
`default_nettype wire
